[hdl/msd_pkg.sv]
// ----------------------------------------------------------------------------
// msd_pkg
// Shared constants and types of the minimum sum partition core.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

	localparam int MAX_TOTAL     = 4096;
	localparam int ITEM_BITS     = 8;
	localparam int WORD_BITS     = 64;
	localparam int WORD_IDX_BITS = 6;
	localparam int SUM_WORDS     = 64;
	localparam int TOTAL_BITS    = 13;
	localparam int DIFF_BITS     = 13;
	localparam int WSHIFT_BITS   = ITEM_BITS - WORD_IDX_BITS;

	typedef logic [WORD_BITS-1:0]     word_t;
	typedef logic [WORD_IDX_BITS-1:0] widx_t;
	typedef logic [WORD_IDX_BITS:0]   shamt_t;
	typedef logic [TOTAL_BITS-1:0]    total_t;
	typedef logic [TOTAL_BITS:0]      total_ext_t;

	localparam shamt_t     WORD_SHAMT = shamt_t'(WORD_BITS);
	localparam widx_t      TOP_BIT    = widx_t'(WORD_BITS - 1);
	localparam widx_t      TOP_WORD   = widx_t'(SUM_WORDS - 1);
	localparam total_ext_t MAX_SUM    = total_ext_t'(MAX_TOTAL);
	localparam total_t     OVF_TOTAL  = total_t'(MAX_TOTAL + 1);

endpackage

`default_nettype wire

[hdl/min_subset_sum_difference_core.sv]
// ----------------------------------------------------------------------------
// min_subset_sum_difference_core
// Minimum sum partition: reachable subset sums kept as a bitset in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the item channel (item_value, last_item) under item_valid
//   and item_stall. The block takes one item at a time; item_stall is high
//   while an item is being worked on or a finished result waits to be loaded.
//   Each nonzero item rewrites the 64-word bitset, one word per cycle from
//   the top word down to word item_value/64, through a memory with two read
//   ports and one write port. A zero item or one that overflows leaves the
//   bitset as it is.
//   On the last item the search walks the words down from half the total,
//   reading and checking each word visited, locates the bit in ST_FIND1 and
//   ST_FIND2, then the result is placed in the output register under result_valid.
//   A result waiting under result_stall holds; the next set is taken in
//   meanwhile, and only its own result waits for the register to free up.
//   Reset clears the per-word valid bits, the total and the overflow flag,
//   so only sum zero is reachable; no clearing pass is run. The same clear
//   happens when a result enters the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module min_subset_sum_difference_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [msd_pkg::ITEM_BITS-1:0] item_value,
	input  wire logic                          last_item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [msd_pkg::DIFF_BITS-1:0]      min_difference,
	output logic                               overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_ADD_WAIT,
		ST_FLUSH,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_FIND1,
		ST_FIND2
	} state_t;

	state_t state_q;
	logic   result_pend_q;

	msd_pkg::word_t mem [msd_pkg::SUM_WORDS];
	msd_pkg::word_t rd_a_s1, rd_b_s1;
	logic           va_s1, vb_s1, a0_s1, b0_s1;
	logic           rv_s1;
	msd_pkg::widx_t idx_s1;

	logic [msd_pkg::SUM_WORDS-1:0] vld_q;
	msd_pkg::total_t               total_q;
	logic                          ovf_q;

	msd_pkg::widx_t                   rd_idx_q;
	logic [msd_pkg::WSHIFT_BITS-1:0]  ws_q;
	msd_pkg::widx_t                   bs_q;
	logic                             last_q;

	msd_pkg::word_t hd_dst_q, hd_src_q;
	msd_pkg::widx_t hd_idx_q;
	logic           hd_have_q;

	msd_pkg::widx_t sw_q, sb_q;
	logic           first_q;
	msd_pkg::word_t fw_q;
	logic [2:0]     grp_q;
	logic [7:0]     byte_q;

	logic [msd_pkg::DIFF_BITS-1:0] diff_q;
	logic                          rovf_q;

	msd_pkg::widx_t     rd_addr_a, rd_addr_b;
	msd_pkg::word_t     word_a, word_b, low_w, wr_data, srch_mask, srch_word;
	logic               wr_en;
	msd_pkg::shamt_t    rshift;
	msd_pkg::total_ext_t sum_t;
	logic [msd_pkg::TOTAL_BITS-2:0] half_t;
	logic [2:0]         grp_sel, bit_sel;
	logic               out_free;

	assign item_stall = (state_q != ST_IDLE) || result_pend_q;
	assign out_free   = !result_valid || !result_stall;

	assign sum_t  = {1'b0, total_q} + msd_pkg::total_ext_t'(item_value);
	assign half_t = sum_t[msd_pkg::TOTAL_BITS-1:1];

	always_comb begin
		case (state_q)
			ST_SRCH_RD: rd_addr_a = sw_q;
			default:    rd_addr_a = rd_idx_q;
		endcase
	end
	assign rd_addr_b = rd_idx_q - msd_pkg::widx_t'(ws_q);

	assign word_a = va_s1 ? rd_a_s1 : msd_pkg::word_t'(a0_s1);
	assign word_b = vb_s1 ? rd_b_s1 : msd_pkg::word_t'(b0_s1);

	assign wr_en  = hd_have_q && (rv_s1 || (state_q == ST_FLUSH));
	assign low_w  = (state_q == ST_FLUSH) ? '0 : word_b;
	assign rshift = msd_pkg::WORD_SHAMT - {1'b0, bs_q};
	assign wr_data = hd_dst_q | (hd_src_q << bs_q) |
		((bs_q == '0) ? '0 : (low_w >> rshift));

	assign srch_mask = first_q ? ('1 >> (msd_pkg::TOP_BIT - sb_q)) : '1;
	assign srch_word = word_a & srch_mask;

	always_comb begin
		grp_sel = '0;
		for (int k = 0; k < 8; k++) begin
			if (|fw_q[k*8 +: 8]) grp_sel = 3'(k);
		end
		bit_sel = '0;
		for (int j = 0; j < 8; j++) begin
			if (byte_q[j]) bit_sel = 3'(j);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[hd_idx_q] <= wr_data;
		rd_a_s1 <= mem[rd_addr_a];
		rd_b_s1 <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_pend_q  <= 1'b0;
			result_valid   <= 1'b0;
			min_difference <= '0;
			overflow       <= 1'b0;
			vld_q          <= '0;
			total_q        <= '0;
			ovf_q          <= 1'b0;
			va_s1          <= 1'b0;
			vb_s1          <= 1'b0;
			a0_s1          <= 1'b0;
			b0_s1          <= 1'b0;
			rv_s1          <= 1'b0;
			idx_s1         <= '0;
			rd_idx_q       <= '0;
			ws_q           <= '0;
			bs_q           <= '0;
			last_q         <= 1'b0;
			hd_dst_q       <= '0;
			hd_src_q       <= '0;
			hd_idx_q       <= '0;
			hd_have_q      <= 1'b0;
			sw_q           <= '0;
			sb_q           <= '0;
			first_q        <= 1'b0;
			fw_q           <= '0;
			grp_q          <= '0;
			byte_q         <= '0;
			diff_q         <= '0;
			rovf_q         <= 1'b0;
		end else begin
			va_s1  <= vld_q[rd_addr_a];
			vb_s1  <= vld_q[rd_addr_b];
			a0_s1  <= (rd_addr_a == '0);
			b0_s1  <= (rd_addr_b == '0);
			rv_s1  <= (state_q == ST_ADD);
			idx_s1 <= rd_idx_q;

			if (wr_en) vld_q[hd_idx_q] <= 1'b1;

			if (rv_s1) begin
				hd_dst_q  <= word_a;
				hd_src_q  <= word_b;
				hd_idx_q  <= idx_s1;
				hd_have_q <= 1'b1;
			end

			// load a finished result and return the store to reset
			if (result_pend_q && out_free) begin
				result_valid   <= 1'b1;
				min_difference <= diff_q;
				overflow       <= rovf_q;
				result_pend_q  <= 1'b0;
				vld_q          <= '0;
				total_q        <= '0;
				ovf_q          <= 1'b0;
			end else if (result_valid && !result_stall) begin
				// drop the result on transfer
				result_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid && !item_stall) begin
						rd_idx_q  <= msd_pkg::TOP_WORD;
						ws_q      <= item_value[msd_pkg::ITEM_BITS-1:msd_pkg::WORD_IDX_BITS];
						bs_q      <= item_value[msd_pkg::WORD_IDX_BITS-1:0];
						last_q    <= last_item;
						hd_have_q <= 1'b0;
						first_q   <= 1'b1;
						sw_q      <= half_t[msd_pkg::TOTAL_BITS-2:msd_pkg::WORD_IDX_BITS];
						sb_q      <= half_t[msd_pkg::WORD_IDX_BITS-1:0];
						if (ovf_q || (sum_t > msd_pkg::MAX_SUM)) begin
							ovf_q   <= 1'b1;
							total_q <= msd_pkg::OVF_TOTAL;
							if (last_item) begin
								diff_q        <= '0;
								rovf_q        <= 1'b1;
								result_pend_q <= 1'b1;
							end
						end else begin
							total_q <= sum_t[msd_pkg::TOTAL_BITS-1:0];
							if (item_value != '0) begin
								state_q <= ST_ADD;
							end else if (last_item) begin
								state_q <= ST_SRCH_RD;
							end
						end
					end
				end
				ST_ADD: begin
					if (rd_idx_q == msd_pkg::widx_t'(ws_q)) begin
						state_q <= ST_ADD_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q - msd_pkg::widx_t'(1);
					end
				end
				ST_ADD_WAIT: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					hd_have_q <= 1'b0;
					state_q   <= last_q ? ST_SRCH_RD : ST_IDLE;
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CHK;
				end
				ST_SRCH_CHK: begin
					if (srch_word != '0) begin
						fw_q    <= srch_word;
						state_q <= ST_FIND1;
					end else if (sw_q == '0) begin
						diff_q        <= total_q;
						rovf_q        <= 1'b0;
						result_pend_q <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						sw_q    <= sw_q - msd_pkg::widx_t'(1);
						first_q <= 1'b0;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_FIND1: begin
					grp_q   <= grp_sel;
					byte_q  <= fw_q[{grp_sel, 3'b000} +: 8];
					state_q <= ST_FIND2;
				end
				ST_FIND2: begin
					diff_q        <= total_q - {sw_q, grp_q, bit_sel, 1'b0};
					rovf_q        <= 1'b0;
					result_pend_q <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
